// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, command and status codes and cell types for the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]         count_t;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_PEEK_BACK  = 3'd4,
        CMD_PEEK_FRONT = 3'd5,
        CMD_CLEAR      = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_BACK,
        OP_POP_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_CLEAR
    } cell_op_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic  occ;
        word_t data;
    } cell_state_t;

endpackage

// ===== src/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the deque row: holds a word and an occupied flag, shifts
// toward either neighbor, and takes or drops the back word.
// ----------------------------------------------------------------------------
module dq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dq_pkg::cell_op_t     op,
    input  dq_pkg::word_t        push_value,
    input  dq_pkg::cell_state_t  left,
    input  dq_pkg::cell_state_t  right,
    output dq_pkg::cell_state_t  state,
    output dq_pkg::word_t        tail_word
);
    import dq_pkg::*;

    logic  occ_reg;
    logic  occ_next;
    word_t data_reg;
    word_t data_next;
    logic  is_tail;
    logic  is_slot;

    // occupied cells form a run from the front; tail is its last cell,
    // slot is the first free cell after it
    assign is_tail = occ_reg & ~right.occ;
    assign is_slot = ~occ_reg & left.occ;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        case (op)
            OP_PUSH_BACK:
            begin
                if (is_slot)
                begin
                    occ_next  = 1'b1;
                    data_next = push_value;
                end
            end
            OP_POP_BACK:
            begin
                if (is_tail)
                    occ_next = 1'b0;
            end
            OP_PUSH_FRONT:
            begin
                occ_next  = left.occ;
                data_next = left.data;
            end
            OP_POP_FRONT:
            begin
                occ_next  = right.occ;
                data_next = right.data;
            end
            OP_CLEAR:
                occ_next = 1'b0;
            default:
            begin
                occ_next  = occ_reg;
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign state.occ  = occ_reg;
    assign state.data = data_reg;
    assign tail_word  = is_tail ? data_reg : '0;

endmodule

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words built as a shifting row of cells.
// ----------------------------------------------------------------------------
// One command per cycle while in_ready is high: each accepted item is decoded
// in the cycle it is taken, the row of cells updates at that edge, and the
// result (value read, status, occupancy) sits in an output register the next
// cycle. The front word always lives in cell 0, so push/pop at the front
// shift the whole row by one; the back word is the last occupied cell and is
// picked by an OR of the cells' tail outputs. Input stays ready while the
// output register is empty or being drained, so a new item can be taken as
// the last result leaves. Clear empties every cell at once.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            command,
    input  dq_pkg::word_t         push_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dq_pkg::word_t         read_value,
    output logic [1:0]            status,
    output dq_pkg::count_t        occupancy
);
    import dq_pkg::*;

    cell_state_t cells     [DEPTH];
    word_t       tail_words[DEPTH];
    cell_op_t    op;

    count_t  count_reg;
    count_t  count_next;
    logic    full;
    logic    empty;
    logic    fire;
    word_t   back_word;
    word_t   rd;
    status_t st;

    logic    out_valid_reg;
    logic    out_valid_next;
    word_t   read_value_reg;
    status_t status_reg;
    count_t  occupancy_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_state_t left_in;
            cell_state_t right_in;

            if (gi == 0)
            begin : g_first
                assign left_in.occ  = 1'b1;
                assign left_in.data = push_value;
            end
            else
            begin : g_mid_l
                assign left_in = cells[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in.occ  = 1'b0;
                assign right_in.data = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cells[gi+1];
            end

            dq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .push_value (push_value),
                .left       (left_in),
                .right      (right_in),
                .state      (cells[gi]),
                .tail_word  (tail_words[gi])
            );
        end
    endgenerate

    // at most one cell is the tail, so an OR picks the back word
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
            back_word = back_word | tail_words[i];
    end

    assign full     = (count_reg == count_t'(DEPTH));
    assign empty    = (count_reg == '0);
    assign in_ready = ~out_valid_reg | out_ready;
    assign fire     = in_valid & in_ready;

    always_comb
    begin
        op         = OP_HOLD;
        rd         = '0;
        st         = ST_OK;
        count_next = count_reg;
        case (command_t'(command))
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    op         = (command == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                    count_next = count_reg + count_t'(1);
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    rd = back_word;
                    if (command == CMD_POP_BACK)
                    begin
                        op         = OP_POP_BACK;
                        count_next = count_reg - count_t'(1);
                    end
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    rd = cells[0].data;
                    if (command == CMD_POP_FRONT)
                    begin
                        op         = OP_POP_FRONT;
                        count_next = count_reg - count_t'(1);
                    end
                end
            end
            CMD_CLEAR:
            begin
                op         = OP_CLEAR;
                count_next = '0;
            end
            default:
            begin
                op         = OP_HOLD;
                count_next = count_reg;
            end
        endcase
        if (!fire)
        begin
            op         = OP_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg <= rd;
            status_reg     <= st;
            occupancy_reg  <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign occupancy  = occupancy_reg;

endmodule
